// ----- hw/rtl/adlm_pkg.sv -----
// Shared types and constants for the angle delta to level median unit.
// No dependencies; imported by every module of the block.
package adlm_pkg;

    // Field widths
    localparam int ANGLE_W = 13;
    localparam int DELTA_W = 14;
    localparam int ACC_W   = 16;
    localparam int SUM_W   = 17;
    localparam int SPAN_W  = 11;
    localparam int LEVEL_W = 14;
    localparam int DEG_W   = 12;
    localparam int MAG_W   = 11;
    localparam int PROD_W  = MAG_W + LEVEL_W;
    localparam int SLV_W   = PROD_W + 2;
    localparam int DCNT_W  = $clog2(PROD_W);

    // Median window
    localparam int MEDIAN_TAPS = 9;
    localparam int TAP_W       = $clog2(MEDIAN_TAPS);
    localparam int CNT_W       = $clog2(MEDIAN_TAPS + 1);
    localparam int MEDIAN_MID  = MEDIAN_TAPS / 2;

    // Arithmetic constants
    localparam int PITCH_LIMIT = 480;
    localparam int SIDE_LIMIT  = 1600;
    localparam int ACC_LOW     = -80;
    localparam int ACC_HIGH    = 32767;
    localparam int SPAN_MARGIN = 5;

    // Configuration
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int SPAN_RESET   = 127;
    localparam int MAPTOP_RESET = 127;

    typedef enum logic [1:0] {
        MODE_PROCESS = 2'd0,
        MODE_TRACK   = 2'd1,
        MODE_ROTATE  = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        AXIS_PITCH = 2'd0,
        AXIS_YAW   = 2'd1,
        AXIS_ROLL  = 2'd2,
        AXIS_SPARE = 2'd3
    } axis_t;

    typedef enum logic {
        REG_SPAN   = 1'b0,
        REG_MAPTOP = 1'b1
    } reg_idx_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic lvl;
        logic med_step;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_process;
        logic div_last;
        logic med_found;
        logic out_free;
    } status_t;

endpackage

// ----- hw/rtl/adlm_ctrl.sv -----
// Sequencing state machine of the angle delta to level median unit.
// Depends on adlm_pkg; drives the datapath through cmd_t, reads status_t.
module adlm_ctrl
    import adlm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_LVL  = 6'b001000,
        ST_MED  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (status.is_process) state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) state_next = ST_LVL;
            end
            ST_LVL: begin
                cmd.lvl    = 1'b1;
                state_next = ST_MED;
            end
            ST_MED: begin
                cmd.med_step = 1'b1;
                if (status.med_found) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

endmodule

// ----- hw/rtl/adlm_datapath.sv -----
// Datapath: axis state, accumulators, multiplier, restoring divider,
// median history and output register. Depends on adlm_pkg.
module adlm_datapath
    import adlm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [1:0]                s_mode,
    input  logic signed [ANGLE_W-1:0] s_pitch_angle,
    input  logic signed [ANGLE_W-1:0] s_yaw_angle,
    input  logic signed [ANGLE_W-1:0] s_roll_angle,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [LEVEL_W-1:0]        m_level,
    input  logic [SPAN_W-1:0]         span,
    input  logic [LEVEL_W-1:0]        map_top,
    input  cmd_t                      cmd,
    output status_t                   status
);

    axis_t axis_reg;
    logic signed [ANGLE_W-1:0] last_reg [3];
    logic signed [ACC_W-1:0]   acc_reg  [3];

    logic signed [DEG_W-1:0]   x_reg;
    logic [SPAN_W-1:0]         div_reg;
    logic                      pitch_reg;
    logic                      neg_reg;
    logic [LEVEL_W-1:0]        top_reg;
    logic [PROD_W-1:0]         quo_reg;
    logic [SPAN_W-1:0]         rem_reg;
    logic [DCNT_W-1:0]         dcnt_reg;

    logic [LEVEL_W-1:0]        hist_reg [MEDIAN_TAPS];
    logic [TAP_W-1:0]          pos_reg;
    logic [TAP_W-1:0]          idx_reg;
    logic [LEVEL_W-1:0]        med_reg;
    logic                      m_valid_reg;
    logic [LEVEL_W-1:0]        m_level_reg;

    // Axis selection; the spare code behaves as pitch
    logic [1:0] sel;
    logic       is_pitch;
    always_comb begin
        case (axis_reg)
            AXIS_YAW:  sel = 2'd1;
            AXIS_ROLL: sel = 2'd2;
            default:   sel = 2'd0;
        endcase
    end
    assign is_pitch = (sel == 2'd0);

    logic signed [ANGLE_W-1:0] angle;
    always_comb begin
        case (sel)
            2'd1:    angle = s_yaw_angle;
            2'd2:    angle = s_roll_angle;
            default: angle = s_pitch_angle;
        endcase
    end

    // Delta, jump rejection and accumulator clamp
    logic signed [DELTA_W-1:0] delta_raw, delta, limit;
    logic [SPAN_W-1:0]         div_sel;
    logic [ACC_W:0]            hi_raw;
    logic signed [SUM_W-1:0]   hi, sum, acc_new17;
    logic signed [ACC_W-1:0]   acc_new;
    logic signed [ACC_W-1:0]   acc_round;
    always_comb begin
        delta_raw = DELTA_W'(angle) - DELTA_W'(last_reg[sel]);
        limit     = is_pitch ? DELTA_W'(PITCH_LIMIT) : DELTA_W'(SIDE_LIMIT);
        delta     = (delta_raw <= -limit || delta_raw >= limit) ? '0 : delta_raw;
        div_sel   = is_pitch ? (span >> 1) : span;
        hi_raw    = (ACC_W+1)'((ACC_W+1)'(div_sel) + (ACC_W+1)'(SPAN_MARGIN)) << 4;
        hi        = (hi_raw > (ACC_W+1)'(ACC_HIGH)) ? SUM_W'(ACC_HIGH)
                                                    : SUM_W'(signed'({1'b0, hi_raw}));
        sum       = SUM_W'(acc_reg[sel]) + SUM_W'(delta);
        if (sum < SUM_W'(ACC_LOW))  acc_new17 = SUM_W'(ACC_LOW);
        else if (sum > hi)          acc_new17 = hi;
        else                        acc_new17 = sum;
        acc_new   = acc_new17[ACC_W-1:0];
        // Truncate toward zero on the divide by 16
        acc_round = acc_new + (acc_new[ACC_W-1] ? ACC_W'(15) : ACC_W'(0));
    end

    // Item load and per-mode state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg <= AXIS_PITCH;
            for (int i = 0; i < 3; i++) begin
                last_reg[i] <= '0;
                acc_reg[i]  <= '0;
            end
        end else if (cmd.load) begin
            case (mode_t'(s_mode))
                MODE_PROCESS: begin
                    acc_reg[sel]  <= acc_new;
                    last_reg[sel] <= angle;
                end
                MODE_TRACK: begin
                    last_reg[0] <= s_pitch_angle;
                    last_reg[1] <= s_yaw_angle;
                    last_reg[2] <= s_roll_angle;
                end
                MODE_ROTATE: begin
                    case (axis_reg)
                        AXIS_PITCH: axis_reg <= AXIS_YAW;
                        AXIS_YAW:   axis_reg <= AXIS_ROLL;
                        default:    axis_reg <= AXIS_PITCH;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Operand capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg     <= DEG_W'(acc_round >>> 4);
            div_reg   <= (div_sel == '0) ? SPAN_W'(1) : div_sel;
            pitch_reg <= is_pitch;
            top_reg   <= map_top;
        end
    end

    // Magnitude product, then restoring division one bit a cycle
    logic [MAG_W-1:0]  x_mag;
    logic [SPAN_W:0]   trial;
    assign x_mag = x_reg[DEG_W-1] ? MAG_W'(-x_reg) : MAG_W'(x_reg);
    assign trial = {rem_reg, quo_reg[PROD_W-1]} - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            quo_reg  <= PROD_W'(x_mag * top_reg);
            neg_reg  <= x_reg[DEG_W-1];
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            if (!trial[SPAN_W]) begin
                rem_reg <= trial[SPAN_W-1:0];
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[SPAN_W-2:0], quo_reg[PROD_W-1]};
                quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
    end
    assign status.div_last = (dcnt_reg == DCNT_W'(PROD_W - 1));

    // Level and clamp
    logic signed [SLV_W-1:0] sq, lv;
    logic [LEVEL_W-1:0]      lv_clamped;
    always_comb begin
        sq = neg_reg ? -SLV_W'(quo_reg) : SLV_W'(quo_reg);
        lv = pitch_reg ? (SLV_W'(top_reg) - sq) : sq;
        if (lv < 0)                       lv_clamped = '0;
        else if (lv > SLV_W'(top_reg))    lv_clamped = top_reg;
        else                              lv_clamped = lv[LEVEL_W-1:0];
    end

    // History ring, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            for (int i = 0; i < MEDIAN_TAPS; i++) hist_reg[i] <= '0;
        end else if (cmd.lvl) begin
            hist_reg[pos_reg] <= lv_clamped;
            pos_reg <= (pos_reg == TAP_W'(MEDIAN_TAPS - 1)) ? '0 : pos_reg + TAP_W'(1);
        end
    end

    // Median scan: one candidate per cycle against all taps
    logic [LEVEL_W-1:0]     cand;
    logic [MEDIAN_TAPS-1:0] lt_vec, le_vec;
    logic [CNT_W-1:0]       n_lt, n_le;
    always_comb begin
        cand = hist_reg[idx_reg];
        for (int j = 0; j < MEDIAN_TAPS; j++) begin
            lt_vec[j] = hist_reg[j] <  cand;
            le_vec[j] = hist_reg[j] <= cand;
        end
        n_lt = CNT_W'($countones(lt_vec));
        n_le = CNT_W'($countones(le_vec));
    end
    assign status.med_found = (n_lt <= CNT_W'(MEDIAN_MID)) && (n_le > CNT_W'(MEDIAN_MID));

    always_ff @(posedge aclk) begin
        if (cmd.lvl) begin
            idx_reg <= '0;
        end else if (cmd.med_step) begin
            idx_reg <= idx_reg + TAP_W'(1);
            if (status.med_found) med_reg <= cand;
        end
    end

    // Output register
    assign status.out_free   = !m_valid_reg || m_ready;
    assign status.is_process = (mode_t'(s_mode) == MODE_PROCESS);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.out_load) m_level_reg <= med_reg;
    end
    assign m_valid = m_valid_reg;
    assign m_level = m_level_reg;

endmodule

// ----- hw/rtl/angle_delta_to_level_median_unit.sv -----
// Angle delta to level with a 9-tap sliding median. A process request
// is accepted, multiplied, passed through the restoring divider
// (one quotient bit per cycle), written into the history and scanned for
// the median (one candidate per cycle), and then loaded into the output
// register. The final step waits as long as an earlier level is still
// held by a stalled output. Track, rotate and unused-mode requests give
// no result and leave the input open. A new request may be taken while
// the previous level still waits at the output. Configuration sits on an
// APB port: span at 0x0, map_top at 0x4.
module angle_delta_to_level_median_unit
    import adlm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_mode,
    input  logic signed [ANGLE_W-1:0] s_pitch_angle,
    input  logic signed [ANGLE_W-1:0] s_yaw_angle,
    input  logic signed [ANGLE_W-1:0] s_roll_angle,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [LEVEL_W-1:0]        m_level,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    logic [SPAN_W-1:0]  span_reg;
    logic [LEVEL_W-1:0] map_top_reg;
    cmd_t               cmd;
    status_t            status;

    // Register file
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_reg    <= SPAN_W'(SPAN_RESET);
            map_top_reg <= LEVEL_W'(MAPTOP_RESET);
        end else if (psel && penable && pwrite) begin
            case (reg_idx_t'(paddr[2]))
                REG_SPAN:   span_reg    <= pwdata[SPAN_W-1:0];
                REG_MAPTOP: map_top_reg <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[2]))
            REG_SPAN:   prdata = PDATA_W'(span_reg);
            REG_MAPTOP: prdata = PDATA_W'(map_top_reg);
            default:    prdata = '0;
        endcase
    end

    adlm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    adlm_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_mode        (s_mode),
        .s_pitch_angle (s_pitch_angle),
        .s_yaw_angle   (s_yaw_angle),
        .s_roll_angle  (s_roll_angle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_level       (m_level),
        .span          (span_reg),
        .map_top       (map_top_reg),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

// ----- hw/rtl/adlm_checker.sv -----
// Port-level checks for angle_delta_to_level_median_unit, bound to it.
// Depends on adlm_pkg.
module adlm_checker
    import adlm_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_mode,
    input logic               m_valid,
    input logic               m_ready,
    input logic [LEVEL_W-1:0] m_level,
    input logic               pready
);

    // Output empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // A process request keeps the input closed next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == MODE_PROCESS) |=> !s_ready)
        else $error("input open right after process request");

    // A non-process request leaves the input open
    a_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode != MODE_PROCESS) |=> s_ready)
        else $error("input closed after non-process request");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind angle_delta_to_level_median_unit adlm_checker u_adlm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_mode  (s_mode),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_level (m_level),
    .pready  (pready)
);

// ----- dv/tb_angle_delta_to_level_median_unit.sv -----
// Self-checking testbench for angle_delta_to_level_median_unit.
// Holds its own level predictor and a scoreboard class; depends on adlm_pkg and the RTL only.
// Drives angle requests and APB writes, and checks each emitted level in order.
module tb_angle_delta_to_level_median_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import adlm_pkg::*;

    // Level predictor plus queue of expected levels
    class level_scoreboard;
        int unsigned span_cfg;
        int unsigned top_cfg;
        axis_t       cur_axis;
        int          last_ang [3];
        int          acc_ang [3];
        int unsigned hist [MEDIAN_TAPS];
        int unsigned hist_pos;
        logic [LEVEL_W-1:0] level_q [$];
        int          mismatches;
        int          levels_seen;

        function new();
            span_cfg = SPAN_RESET;
            top_cfg  = MAPTOP_RESET;
            cur_axis = AXIS_PITCH;
            foreach (last_ang[i]) begin
                last_ang[i] = 0;
                acc_ang[i]  = 0;
            end
            foreach (hist[i]) hist[i] = 0;
            hist_pos    = 0;
            mismatches  = 0;
            levels_seen = 0;
        endfunction

        function int unsigned median_of(int unsigned v);
            int unsigned srt [MEDIAN_TAPS];
            int unsigned tmp;
            hist[hist_pos] = v;
            hist_pos = (hist_pos + 1) % MEDIAN_TAPS;
            srt = hist;
            for (int i = 0; i < MEDIAN_TAPS; i++)
                for (int j = 0; j < MEDIAN_TAPS - 1 - i; j++)
                    if (srt[j] > srt[j+1]) begin
                        tmp = srt[j]; srt[j] = srt[j+1]; srt[j+1] = tmp;
                    end
            return srt[MEDIAN_MID];
        endfunction

        // Note an accepted request; queue a level for process mode
        function void note_request(mode_t m, int p, int y, int r);
            int ax, ang, lim, d, dv, hi, a, x, lv, top;
            bit pitch;
            if (m == MODE_TRACK) begin
                last_ang[0] = p; last_ang[1] = y; last_ang[2] = r;
                return;
            end
            if (m == MODE_ROTATE) begin
                cur_axis = (cur_axis == AXIS_PITCH) ? AXIS_YAW :
                           (cur_axis == AXIS_YAW) ? AXIS_ROLL : AXIS_PITCH;
                return;
            end
            if (m != MODE_PROCESS) return;
            ax    = (cur_axis == AXIS_YAW) ? 1 : (cur_axis == AXIS_ROLL) ? 2 : 0;
            pitch = (ax == 0);
            ang   = (ax == 0) ? p : (ax == 1) ? y : r;
            lim   = pitch ? PITCH_LIMIT : SIDE_LIMIT;
            d     = ang - last_ang[ax];
            if (d <= -lim || d >= lim) d = 0;
            dv = pitch ? int'(span_cfg / 2) : int'(span_cfg);
            hi = (dv + SPAN_MARGIN) * 16;
            if (hi > ACC_HIGH) hi = ACC_HIGH;
            a = acc_ang[ax] + d;
            if (a < ACC_LOW) a = ACC_LOW;
            if (a > hi) a = hi;
            acc_ang[ax]  = a;
            last_ang[ax] = ang;
            if (dv == 0) dv = 1;
            top = top_cfg;
            x   = a / 16;
            lv  = pitch ? top - (x * top) / dv : (x * top) / dv;
            if (lv < 0) lv = 0;
            if (lv > top) lv = top;
            level_q.push_back(LEVEL_W'(median_of(lv)));
        endfunction

        function void check_level(logic [LEVEL_W-1:0] got);
            logic [LEVEL_W-1:0] want;
            levels_seen++;
            if (level_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected level %0d", got);
                return;
            end
            want = level_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("level mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_mode = '0;
    logic signed [ANGLE_W-1:0] s_pitch_angle = '0;
    logic signed [ANGLE_W-1:0] s_yaw_angle = '0;
    logic signed [ANGLE_W-1:0] s_roll_angle = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [LEVEL_W-1:0]        m_level;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [PDATA_W-1:0]        pwdata = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    level_scoreboard sb = new();
    bit              calm = 1'b0;
    int              n_process = 0;

    angle_delta_to_level_median_unit i_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: random stalls, checks at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_level(m_level);
    end
    always @(negedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 21);
    end

    task automatic write_reg(reg_idx_t idx, int unsigned value);
        @(negedge aclk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= PADDR_W'(4 * int'(idx));
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_SPAN) sb.span_cfg = value & 32'h7FF;
        else sb.top_cfg = value & 32'h3FFF;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drives one request from a falling edge, after random idle gaps unless calm; returns at the accepting edge
    task automatic send_request(mode_t m, int p, int y, int r);
        @(negedge aclk);
        if (!calm) while ($urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= m;
        s_pitch_angle <= ANGLE_W'(p);
        s_yaw_angle   <= ANGLE_W'(y);
        s_roll_angle  <= ANGLE_W'(r);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(m, p, y, r);
        if (m == MODE_PROCESS) n_process++;
    endtask

    // Drop the request line, wait until every level is in, then let the datapath go quiet
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.level_q.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    function automatic int rand_angle();
        return $urandom_range(5760) - 2880;
    endfunction

    // Mostly small moves on all three angles, mostly process requests, with rotates, tracks and unused modes mixed in
    task automatic random_phase(int count);
        int    ang [3];
        int    pick;
        mode_t m;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            m = (pick < 70) ? MODE_PROCESS : (pick < 82) ? MODE_ROTATE :
                (pick < 95) ? MODE_TRACK : MODE_NONE;
            foreach (ang[i]) begin
                if ($urandom_range(9) == 0) ang[i] = rand_angle();
                else begin
                    ang[i] = sb.last_ang[i] + int'($urandom_range(400)) - 200;
                    if (ang[i] > 2880) ang[i] = 2880;
                    if (ang[i] < -2880) ang[i] = -2880;
                end
            end
            send_request(m, ang[0], ang[1], ang[2]);
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extremes, every mode, delta limits, unused mode
        send_request(MODE_PROCESS, 2880, -2880, 2880);
        send_request(MODE_PROCESS, 2880 - 479, 0, 0);
        send_request(MODE_PROCESS, 2880 - 479 - 480, 0, 0);
        send_request(MODE_PROCESS, -2880, 0, 0);
        send_request(MODE_NONE, -1, -1, -1);
        send_request(MODE_TRACK, -2880, 2880, -4096 + 4096);
        send_request(MODE_ROTATE, 0, 0, 0);
        send_request(MODE_PROCESS, 0, 1599 - 2880 + 2880, 0);
        send_request(MODE_PROCESS, 0, 1599 + 1600, 0);
        send_request(MODE_PROCESS, 0, -2880, 0);
        send_request(MODE_ROTATE, 0, 0, 0);
        send_request(MODE_PROCESS, 0, 0, 1599);
        send_request(MODE_PROCESS, 0, 0, 2880);
        send_request(MODE_PROCESS, 0, 0, -2880);
        send_request(MODE_ROTATE, 0, 0, 0);
        send_request(MODE_PROCESS, -1, -1, -1);
        for (int k = 0; k < 8; k++) send_request(MODE_PROCESS, 479 * (k % 2), 0, 0);
        drain();

        // Settings sweep, including extremes and span below two
        random_phase(300);
        drain();
        write_reg(REG_SPAN, 1270); write_reg(REG_MAPTOP, 16383);
        random_phase(300);
        drain();
        write_reg(REG_SPAN, 2); write_reg(REG_MAPTOP, 1);
        random_phase(250);
        drain();
        write_reg(REG_SPAN, 1); write_reg(REG_MAPTOP, 1000);
        random_phase(200);
        drain();
        write_reg(REG_SPAN, 0); write_reg(REG_MAPTOP, 0);
        random_phase(100);
        drain();
        write_reg(REG_SPAN, 32'h7FF); write_reg(REG_MAPTOP, 32'h3FFF);
        calm = 1'b1;
        random_phase(250);
        calm = 1'b0;
        drain();
        write_reg(REG_SPAN, $urandom_range(1270, 2));
        write_reg(REG_MAPTOP, $urandom_range(16383, 1));
        random_phase(300);
        drain();

        $display("Ran %0d process requests through %0d checked levels over seven settings.",
                 n_process, sb.levels_seen);
        if (sb.mismatches == 0 && sb.level_q.size() == 0)
            $display("Testbench completed without errors");
        else begin
            $display("%0d mismatches in total", sb.mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard limit on run time
    initial begin
        #20ms;
        $display("Timed out");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
